@@ rtl/core/maw_pkg.sv @@
// maw_pkg: shared widths, codes and types for the moving average window block
// used by maw_div and moving_average_window; depends on nothing else
package maw_pkg;

    // field and register widths
    localparam int SAMPLE_W       = 32;
    localparam int SUM_W          = 42;
    localparam int CFG_W          = 11;
    localparam int AVG_W          = 32;

    // reset value of the window length register
    localparam logic [CFG_W-1:0] WINDOW_RESET = 11'd16;

    // default ring depth
    localparam int MAX_WINDOW_DEF = 1024;

    // request kinds carried on the input tuser bit
    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // divider status seen by the control sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ rtl/core/moving_average_window.sv @@
// Simple moving average over a window of unsigned 32-bit samples. A sample request
// (tuser = 0) is accepted, then reads the sample ring, updates the running sum,
// loads the divider, runs the bit-serial divider (one quotient bit per cycle over
// the 44-bit numerator 2*sum + n, then its done flag) and posts the result; no new
// request is taken until the result is posted, and a stalled output holds it. A
// restart request (tuser = 1) returns the held average with filling set. The
// result is floor(sum/n + 0.5), n being the samples seen since restart while filling
// and the window length afterwards. Write the window length only while idle and
// follow it with a restart; ring entries never written since reset read as undefined.
//
// moving_average_window: top level, control sequencer, sample ring and running sum
// depends on maw_pkg and maw_div
module moving_average_window
    import maw_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write: window length
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    // input requests
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [31:0] sample
    input  logic                s_axis_tuser,   // [0] kind
    // results
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [AVG_W-1:0]    m_axis_tdata,   // [31:0] average
    output logic                m_axis_tuser    // [0] filling
);

    localparam int IW    = $clog2(MAX_WINDOW);
    localparam int DW    = $clog2(MAX_WINDOW + 1);
    localparam int DEN_W = DW + 1;
    localparam int NUM_W = SUM_W + 2;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]          r_state;
    logic [CFG_W-1:0]    r_window;
    logic [SUM_W-1:0]    r_sum;
    logic [IW-1:0]       r_slot;
    logic                r_fill;
    logic [AVG_W-1:0]    r_held;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_old;
    logic [DW-1:0]       r_div;
    logic                r_out_valid;
    logic [AVG_W-1:0]    r_out_avg;
    logic                r_out_fill;

    logic [SAMPLE_W-1:0] r_ring [MAX_WINDOW];

    logic                w_accept;
    logic                w_out_free;
    logic [DW-1:0]       w_n;
    logic [DW-1:0]       w_slot_inc;
    logic [SUM_W:0]      w_sum_add;
    logic [NUM_W-1:0]    w_num;
    logic [DEN_W-1:0]    w_den;
    logic                w_start;
    t_div_stat           w_div_stat;
    logic [NUM_W-1:0]    w_quot;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // effective window: zero counts as one, saturate at ring depth
    always_comb begin
        if (r_window == '0) begin
            w_n = DW'(1);
        end else if (32'(r_window) > 32'(MAX_WINDOW)) begin
            w_n = DW'(MAX_WINDOW);
        end else begin
            w_n = DW'(r_window);
        end
    end

    assign w_slot_inc = DW'(r_slot) + DW'(1);
    assign w_sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(r_sample);

    // divider operands: (2*sum + n) / (2*n)
    assign w_num   = {1'b0, r_sum, 1'b0} + NUM_W'(r_div);
    assign w_den   = {r_div, 1'b0};
    assign w_start = (r_state == ST_PREP);

    maw_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // sample ring: read on accept, write back the new sample in the cycle after
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old <= r_ring[r_slot];
        end
        if (r_state == ST_READ) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= s_axis_tdata;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window <= i_cfg_data;
        end
    end

    // sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_slot  <= '0;
            r_fill  <= 1'b1;
            r_held  <= '0;
            r_div   <= DW'(1);
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (s_axis_tuser == KIND_RESTART) begin
                            r_sum   <= '0;
                            r_slot  <= '0;
                            r_fill  <= 1'b1;
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    // drop the outgoing sample once the window is full
                    if (r_fill) begin
                        r_div <= w_slot_inc;
                    end else begin
                        r_div <= w_n;
                        r_sum <= (r_sum >= SUM_W'(r_old)) ? r_sum - SUM_W'(r_old) : '0;
                    end
                    // advance the slot, leave fill mode at the last slot
                    if (w_slot_inc >= w_n) begin
                        r_slot <= '0;
                        r_fill <= 1'b0;
                    end else begin
                        r_slot <= IW'(w_slot_inc);
                    end
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_sum   <= w_sum_add[SUM_W] ? '1 : w_sum_add[SUM_W-1:0];
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_held  <= (w_quot[NUM_W-1:AVG_W] != '0) ? '1 : w_quot[AVG_W-1:0];
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_avg  <= r_held;
            r_out_fill <= r_fill;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_avg;
    assign m_axis_tuser  = r_out_fill;

    // a restart leaves an empty window in fill mode
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && s_axis_tuser == KIND_RESTART |=> r_sum == '0 && r_fill && r_slot == '0)
        else $error("restart did not clear the window state");

    // divider is launched exactly from the load state
    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PREP |=> w_div_stat.busy && r_state == ST_DIV)
        else $error("divider not running after load");

    // divider completion only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> r_state == ST_DIV)
        else $error("divider finished outside the wait state");

    // no request taken while a division is still running
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_div_stat.busy)
        else $error("request accepted during division");

    // slot index stays inside the ring
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < 32'(MAX_WINDOW))
        else $error("slot index beyond ring depth");

endmodule

@@ rtl/core/maw_div.sv @@
// maw_div: bit-serial restoring divider, one quotient bit per cycle
// depends on maw_pkg for the status struct
module maw_div
    import maw_pkg::*;
#(
    parameter int NUM_W = 44,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // one restoring step: shift in next numerator bit, try subtract
    always_comb begin
        w_rem_sh = {r_rem, r_num[NUM_W-1]};
        w_diff   = w_rem_sh - {1'b0, r_den};
        w_ge     = (w_rem_sh >= {1'b0, r_den});
    end

    // control: step counter and handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: numerator register collects quotient bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

@@ tb/sv/moving_average_window_tb.sv @@
`timescale 1ns / 1ps
// moving_average_window_tb: self-checking bench for the moving average window block
// drives sample and restart requests with random idling, predicts each rounded average
// and checks results in order; depends on maw_pkg and moving_average_window
module moving_average_window_tb;
    import maw_pkg::*;

    localparam int          RING_DEPTH   = MAX_WINDOW_DEF;
    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 60;
    localparam logic [63:0] SUM_CEIL     = (64'd1 << SUM_W) - 64'd1;

    typedef struct {
        logic [AVG_W-1:0] average;
        logic             filling;
    } t_avg_result;

    // predicts the rounded average of each request and checks results in order
    class average_scoreboard;
        logic [SAMPLE_W-1:0] ring_copy [RING_DEPTH];
        bit                  ring_written [RING_DEPTH];
        logic [63:0]         sum;
        int unsigned         slot;
        bit                  fill;
        logic [AVG_W-1:0]    held;
        logic [CFG_W-1:0]    window_reg;
        t_avg_result         expected_averages [$];
        int unsigned         failures;

        function new();
            sum        = 64'd0;
            slot       = 0;
            fill       = 1'b1;
            held       = '0;
            window_reg = WINDOW_RESET;
            failures   = 0;
            foreach (ring_written[i]) ring_written[i] = 1'b0;
        endfunction

        // zero counts as one, oversize values clamp to the ring depth
        function int unsigned window_len();
            if (window_reg == '0) return 1;
            if (32'(window_reg) > RING_DEPTH) return RING_DEPTH;
            return 32'(window_reg);
        endfunction

        // a sample now would drop a ring entry that was never written
        function bit would_read_unwritten();
            return !fill && !ring_written[slot];
        endfunction

        function int unsigned pending();
            return expected_averages.size();
        endfunction

        // accepted request: update the running state and queue the expected result
        function void note_request(logic kind, logic [SAMPLE_W-1:0] sample);
            int unsigned n;
            logic [63:0] divisor;
            logic [63:0] quotient;
            t_avg_result exp_res;
            n = window_len();
            if (kind == KIND_RESTART) begin
                fill = 1'b1;
                slot = 0;
                sum  = 64'd0;
            end else begin
                if (fill) begin
                    divisor = 64'(slot) + 64'd1;
                end else begin
                    // drop the oldest sample, never below zero
                    sum = (sum >= 64'(ring_copy[slot])) ?
                          sum - 64'(ring_copy[slot]) : 64'd0;
                    divisor = 64'(n);
                end
                sum = sum + 64'(sample);
                if (sum > SUM_CEIL) sum = SUM_CEIL;
                // floor(sum/n + 0.5) in integers
                quotient = (64'd2 * sum + divisor) / (64'd2 * divisor);
                held = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[AVG_W-1:0];
                ring_copy[slot]    = sample;
                ring_written[slot] = 1'b1;
                if (slot + 1 >= n) begin
                    slot = 0;
                    fill = 1'b0;
                end else begin
                    slot = slot + 1;
                end
            end
            exp_res.average = held;
            exp_res.filling = fill;
            expected_averages.push_back(exp_res);
        endfunction

        // accepted result: compare against the oldest expectation
        function void check_result(logic [AVG_W-1:0] average, logic filling);
            t_avg_result exp_res;
            if (expected_averages.size() == 0) begin
                $error("result with no request pending: average %0d filling %0b",
                       average, filling);
                failures++;
                return;
            end
            exp_res = expected_averages.pop_front();
            if (average !== exp_res.average) begin
                $error("average: expected %0d, actual %0d", exp_res.average, average);
                failures++;
            end
            if (filling !== exp_res.filling) begin
                $error("filling: expected %0b, actual %0b", exp_res.filling, filling);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata  = '0;   // [31:0] sample
    logic                s_axis_tuser  = 1'b0; // [0] kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [AVG_W-1:0]    m_axis_tdata;         // [31:0] average
    logic                m_axis_tuser;         // [0] filling

    bit tx_quiet     = 1'b0;
    bit rx_quiet     = 1'b0;
    bit hold_pending = 1'b0;

    average_scoreboard sb = new();

    moving_average_window u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // sample values weighted toward the extremes
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick == 2) return $urandom_range(0, 15);
        if (pick == 3) return 32'hFFFF_FFFF - $urandom_range(0, 15);
        return $urandom();
    endfunction

    // one request on the input stream; starts and ends at a falling edge
    task automatic send_request(input logic kind, input logic [SAMPLE_W-1:0] sample);
        int unsigned gap;
        gap = tx_quiet ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= kind;
        forever begin
            @(posedge i_clk);
            if (s_axis_tvalid && s_axis_tready) break;
        end
        sb.note_request(kind, sample);
        @(negedge i_clk);
    endtask

    // drop valid and wait until every result is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // window length write, only while idle
    task automatic write_window(input logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (i_cfg_valid && o_cfg_ready) break;
        end
        sb.window_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random traffic at one window setting
    task automatic run_phase(input logic [CFG_W-1:0] win, input int count,
                             input int restart_pct, input bit quiet_tx,
                             input bit quiet_rx, input bit hold);
        logic kind;
        wait_idle();
        write_window(win);
        tx_quiet = quiet_tx;
        rx_quiet = quiet_rx;
        if (hold) hold_pending = 1'b1;
        for (int i = 0; i < count; i++) begin
            // restart instead when a sample would drop a never-written entry
            kind = (($urandom_range(0, 99) < restart_pct) ||
                    (i == 0 && $urandom_range(0, 1) == 0) ||
                    sb.would_read_unwritten()) ? KIND_RESTART : KIND_SAMPLE;
            send_request(kind, pick_sample());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // result side backpressure, with an occasional long hold-off
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                stall_left   = HOLD_CYCLES;
                hold_pending = 1'b0;
            end else if (stall_left == 0 && !rx_quiet && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // hang guard
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes and restarts at the reset window
        send_request(KIND_RESTART, 32'hFFFF_FFFF);
        send_request(KIND_SAMPLE, 32'h0000_0000);
        send_request(KIND_SAMPLE, 32'hFFFF_FFFF);
        send_request(KIND_SAMPLE, 32'hFFFF_FFFF);
        send_request(KIND_SAMPLE, 32'h0000_0001);
        send_request(KIND_RESTART, 32'h0000_0000);
        send_request(KIND_SAMPLE, 32'h0000_0001);
        send_request(KIND_RESTART, 32'h8000_0000);

        // half-way rounding and a full window of maximum samples
        wait_idle();
        write_window(11'd2);
        send_request(KIND_SAMPLE, 32'd0);
        send_request(KIND_SAMPLE, 32'd1);
        send_request(KIND_SAMPLE, 32'd2);
        send_request(KIND_SAMPLE, 32'hFFFF_FFFF);
        send_request(KIND_SAMPLE, 32'hFFFF_FFFF);
        send_request(KIND_RESTART, 32'd5);

        // zero window behaves as one
        wait_idle();
        write_window(11'd0);
        send_request(KIND_SAMPLE, 32'd7);
        send_request(KIND_SAMPLE, 32'hFFFF_FFFF);

        // shrink the window part way through the fill, no restart
        wait_idle();
        write_window(11'd8);
        send_request(KIND_RESTART, 32'd0);
        send_request(KIND_SAMPLE, 32'd10);
        send_request(KIND_SAMPLE, 32'd20);
        send_request(KIND_SAMPLE, 32'd30);
        send_request(KIND_SAMPLE, 32'd40);
        send_request(KIND_SAMPLE, 32'd50);
        wait_idle();
        write_window(11'd3);
        send_request(KIND_SAMPLE, 32'd60);
        send_request(KIND_SAMPLE, 32'd70);
        send_request(KIND_SAMPLE, 32'd80);

        // random phases: window, count, restart %, quiet tx, quiet rx, hold-off
        run_phase(11'd3,    80,   4, 1'b0, 1'b0, 1'b0);
        run_phase(11'd1,    40,   5, 1'b1, 1'b1, 1'b0);
        run_phase(11'd16,   80,   3, 1'b0, 1'b0, 1'b0);
        run_phase(11'd7,    60,   3, 1'b1, 1'b0, 1'b1);
        run_phase(11'd2,    60,   6, 1'b0, 1'b0, 1'b0);
        run_phase(11'd0,    30,   5, 1'b0, 1'b0, 1'b0);
        run_phase(11'd31,   60,   2, 1'b0, 1'b1, 1'b0);
        run_phase(11'd5,    60,   4, 1'b0, 1'b0, 1'b0);
        run_phase(11'd64,   100,  1, 1'b0, 1'b0, 1'b0);
        // largest window: oversize value clamps to the ring depth
        run_phase(11'd2047, 100,  0, 1'b0, 1'b0, 1'b0);
        run_phase(11'd1024, 60,   0, 1'b0, 1'b0, 1'b0);
        run_phase(11'd12,   60,   5, 1'b0, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
